[rtl/assert_macros.svh]
// assertion macros for the time-code line sequence checker
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

[rtl/tcls_pkg.sv]
// shared types and constants of the time-code line sequence checker
// no dependencies
`default_nettype none

package tcls_pkg;

	// character codes
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// segment layout
	localparam int POS_W          = 6;   // holds positions up to 63
	localparam int POS_TENS       = 15;
	localparam int POS_UNITS      = 16;
	localparam int SEG_AFTER_DASH = 3;   // next position after the dash

	// seconds arithmetic
	localparam int                SEC_W     = 13;
	localparam logic [SEC_W-1:0]  SEC_BIAS  = 13'd528;  // 10*'0' + '0'
	localparam logic signed [SEC_W-1:0] ARM_LIMIT = 13'sd58;

	// result status codes
	localparam logic [1:0] ST_FIRST   = 2'd0;
	localparam logic [1:0] ST_CONSEC  = 2'd1;
	localparam logic [1:0] ST_SEQ_ERR = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_DASH,
		OP_TAKE
	} op_kind_t;

	// one classified character, front to back
	typedef struct packed {
		op_kind_t         kind;
		logic [7:0]       ch;
		logic [7:0]       hist_hi;   // character two before the dash
		logic [7:0]       hist_lo;   // character just before the dash
		logic [POS_W-1:0] pos;
		logic             last;
		logic             dash;      // dash found on this line so far
		logic [POS_W-1:0] pad_from;  // first position left to pad with zero
	} op_t;

endpackage

`default_nettype wire

[rtl/tcls_front.sv]
// front end: accepts characters, finds the dash, assigns segment positions
// depends on tcls_pkg
`default_nettype none

module tcls_front #(
	parameter int SEGMENT_LENGTH = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_in,
	input  wire logic        line_end,
	input  wire logic        q_full,
	output logic             q_push,
	output tcls_pkg::op_t    q_op
);
	import tcls_pkg::*;

	localparam int CAP_W = $clog2(SEGMENT_LENGTH + 1);

	logic [15:0]      hist_q;
	logic             dash_q;
	logic [CAP_W-1:0] cap_q;

	logic             dash_next;
	logic [CAP_W-1:0] cap_next;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_op         = '0;
		q_op.kind    = OP_NONE;
		q_op.ch      = char_in;
		q_op.hist_hi = hist_q[15:8];
		q_op.hist_lo = hist_q[7:0];
		q_op.pos     = POS_W'(cap_q);
		q_op.last    = line_end;
		dash_next    = dash_q;
		cap_next     = cap_q;
		if (!dash_q) begin
			if (char_in == CHAR_DASH) begin
				q_op.kind = OP_DASH;
				dash_next = 1'b1;
				cap_next  = CAP_W'(SEG_AFTER_DASH);
			end
		end else if (cap_q < CAP_W'(SEGMENT_LENGTH)) begin
			q_op.kind = OP_TAKE;
			cap_next  = cap_q + CAP_W'(1);
		end
		q_op.dash     = dash_next;
		q_op.pad_from = POS_W'(cap_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			dash_q <= 1'b0;
			cap_q  <= '0;
		end else if (q_push) begin
			if (line_end) begin
				hist_q <= '0;
				dash_q <= 1'b0;
				cap_q  <= '0;
			end else begin
				hist_q <= {hist_q[7:0], char_in};
				dash_q <= dash_next;
				cap_q  <= cap_next;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/tcls_queue.sv]
// two-entry queue of classified characters between front and back
// depends on tcls_pkg
`default_nettype none

module tcls_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  tcls_pkg::op_t       op_in,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output tcls_pkg::op_t       head
);
	import tcls_pkg::*;

	op_t        entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/tcls_back.sv]
// back end: segment store, per-position compare, seconds check, result register
// depends on tcls_pkg
`default_nettype none

module tcls_back #(
	parameter int SEGMENT_LENGTH = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           high_speed,
	input  wire logic                           head_valid,
	input  tcls_pkg::op_t                       head,
	output logic                                pop,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [1:0]                          status,
	output logic signed [tcls_pkg::SEC_W-1:0]   line_seconds
);
	import tcls_pkg::*;

	logic [7:0]           seg_q [SEGMENT_LENGTH];
	logic [SEC_W-1:0]     prev_sec_q;
	logic                 armed_q;
	logic                 mis_q;
	logic [7:0]           tens_q;

	logic [SEGMENT_LENGTH-1:0] en;
	logic [SEGMENT_LENGTH-1:0] diff;
	logic [7:0]                raw    [SEGMENT_LENGTH];
	logic [7:0]                stored [SEGMENT_LENGTH];

	logic [7:0]       tens_eff;
	logic [SEC_W-1:0] sec;
	logic [SEC_W-1:0] sec_new;
	logic [SEC_W-1:0] expect_sec;
	logic             mis_now;
	logic             mis_all;
	logic [1:0]       status_next;
	logic [SEC_W-1:0] secout_next;
	logic             armed_next;

	assign pop = head_valid && (!head.last || !out_valid || !out_stall);

	// one lane per segment position
	always_comb begin
		for (int p = 0; p < SEGMENT_LENGTH; p++) begin
			en[p]  = 1'b0;
			raw[p] = 8'h00;
			if (head.kind == OP_DASH && p < SEG_AFTER_DASH) begin
				en[p] = 1'b1;
				if (p == 0) begin
					raw[p] = head.hist_hi;
				end else if (p == 1) begin
					raw[p] = head.hist_lo;
				end else begin
					raw[p] = head.ch;
				end
			end else if (head.kind == OP_TAKE && head.pos == POS_W'(p)) begin
				en[p]  = 1'b1;
				raw[p] = head.ch;
			end else if (head.last && head.dash && POS_W'(p) >= head.pad_from) begin
				// past the line end the positions read as zero
				en[p]  = 1'b1;
				raw[p] = 8'h00;
			end
			stored[p] = (p == POS_TENS || p == POS_UNITS) ? CHAR_SPACE : raw[p];
			diff[p]   = en[p] && (seg_q[p] != stored[p]);
		end
	end

	always_comb begin
		tens_eff   = en[POS_TENS] ? raw[POS_TENS] : tens_q;
		sec        = (SEC_W'(tens_eff) << 3) + (SEC_W'(tens_eff) << 1)
		             + SEC_W'(raw[POS_UNITS]) - SEC_BIAS;
		expect_sec = prev_sec_q + (high_speed ? SEC_W'(1) : SEC_W'(2));
		mis_now    = armed_q && ((|diff) || (en[POS_UNITS] && expect_sec != sec));
		mis_all    = mis_q || mis_now;
		sec_new    = en[POS_UNITS] ? sec : prev_sec_q;

		status_next = ST_FIRST;
		secout_next = '0;
		armed_next  = armed_q;
		if (!head.dash) begin
			if (armed_q) begin
				status_next = ST_SEQ_ERR;
				armed_next  = 1'b0;
			end
		end else begin
			secout_next = sec_new;
			if (armed_q) begin
				if (mis_all) begin
					status_next = ST_SEQ_ERR;
					armed_next  = 1'b0;
				end else begin
					status_next = ST_CONSEC;
				end
			end else begin
				armed_next = ($signed(sec_new) < ARM_LIMIT);
			end
		end
	end

	// segment store, written only while disarmed
	always_ff @(posedge clk) begin
		if (pop && !armed_q) begin
			for (int p = 0; p < SEGMENT_LENGTH; p++) begin
				if (en[p]) begin
					seg_q[p] <= stored[p];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sec_q <= '0;
			armed_q    <= 1'b0;
			mis_q      <= 1'b0;
			tens_q     <= '0;
		end else if (pop) begin
			if (en[POS_UNITS]) begin
				prev_sec_q <= sec;
			end
			if (head.last) begin
				mis_q   <= 1'b0;
				tens_q  <= '0;
				armed_q <= armed_next;
			end else begin
				mis_q <= mis_all;
				if (en[POS_TENS]) begin
					tens_q <= raw[POS_TENS];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (pop && head.last) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			status       <= status_next;
			line_seconds <= secout_next;
		end
	end

endmodule

`default_nettype wire

[rtl/time_code_line_sequence_check_top.sv]
// time-code line sequence checker: one character accepted per cycle, back to back, while the queue is not full
// the result of a line is registered in the back end when its last character leaves the queue
// throughput: one character per cycle; the front stalls only when the two-entry queue is full
// the back stalls only while a finished result waits on out_stall
// reset: asynchronous, clears line state, armed flag, kept seconds; high_speed resets to 1
// the kept segment store has no reset and is filled by the first captured line
`default_nettype none

`include "assert_macros.svh"

module time_code_line_sequence_check_top #(
	parameter int SEGMENT_LENGTH = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// character input
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    char_in,
	input  wire logic                          line_end,
	// result output
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         status,
	output logic signed [tcls_pkg::SEC_W-1:0]  line_seconds,
	// configuration write
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          high_speed
);
	import tcls_pkg::*;

	// baud-rate selection, one or two second step
	logic high_speed_q;

	// front to queue request
	logic q_push;
	logic q_full;
	op_t  q_op;

	// queue to back request
	logic q_head_valid;
	logic q_pop;
	op_t  q_head;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_speed_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			high_speed_q <= high_speed;
		end
	end

	// classify characters and assign segment positions
	tcls_front #(
		.SEGMENT_LENGTH (SEGMENT_LENGTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.char_in  (char_in),
		.line_end (line_end),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_op     (q_op)
	);

	// short queue so front and back stall independently
	tcls_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.op_in      (q_op),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// compare against the kept segment and seconds, produce results
	tcls_back #(
		.SEGMENT_LENGTH (SEGMENT_LENGTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.high_speed   (high_speed_q),
		.head_valid   (q_head_valid),
		.head         (q_head),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.line_seconds (line_seconds)
	);

	// a new result only comes from a line end leaving the queue
	`ASSERT_PROP(a_result_from_line_end, clk, arst_n, (out_valid && !$past(out_valid)) |-> $past(q_pop && q_head.last), "result without a line end")
	// a line end never overwrites a waiting result
	`ASSERT_PROP(a_no_result_overwrite, clk, arst_n, (q_pop && q_head.last) |-> !(out_valid && out_stall), "waiting result overwritten")
	// ordinary characters leave a waiting result untouched
	`ASSERT_PROP(a_char_keeps_result, clk, arst_n, (q_pop && !q_head.last && out_valid && out_stall) |=> ($stable(status) && $stable(line_seconds)), "result changed by a character")
	// status is one of the three defined codes
	`ASSERT_NEVER(a_status_code, clk, arst_n, out_valid && status != ST_FIRST && status != ST_CONSEC && status != ST_SEQ_ERR, "undefined status code")

endmodule

`default_nettype wire
